FILE: design/iprol_pkg.sv
// shared constants, codes and types for the address range owner lookup table
package iprol_pkg;

  // table geometry
  localparam int TABLE_DEPTH = 256;
  localparam int IDX_W       = $clog2(TABLE_DEPTH);
  localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

  // field widths
  localparam int FUNC_W   = 2;
  localparam int ADDR_W   = 32;
  localparam int PREFIX_W = 24;
  localparam int OCTET_W  = 8;
  localparam int OWNER_W  = 32;

  // configuration port
  localparam int CFG_ADDR_W = 2;
  localparam int CFG_DATA_W = 32;
  localparam logic [CFG_ADDR_W-1:0] REG_LOOKUP_DISABLED = CFG_ADDR_W'(0);

  // operation codes
  typedef enum logic [FUNC_W-1:0] {
    FUNC_LOOKUP = 2'd0,
    FUNC_INSERT = 2'd1,
    FUNC_CLEAR  = 2'd2,
    FUNC_QUERY  = 2'd3
  } func_t;

  // stored entry key: prefix, first octet, last octet
  typedef struct packed {
    logic [PREFIX_W-1:0] prefix;
    logic [OCTET_W-1:0]  first;
    logic [OCTET_W-1:0]  last;
  } key_t;

  localparam int KEY_W = $bits(key_t);

  // one result item
  typedef struct packed {
    logic               hit;
    logic [OWNER_W-1:0] owner;
    logic               present;
    logic               rejected;
  } res_t;

  // table memory access from the sequencer
  typedef struct packed {
    logic               we;
    logic [IDX_W-1:0]   waddr;
    key_t               wkey;
    logic [OWNER_W-1:0] wowner;
    logic               re;
    logic [IDX_W-1:0]   raddr;
  } mem_req_t;

endpackage

FILE: design/ip_prefix_range_owner_lookup.sv
// top level of the address range owner lookup table
//
//   channel  direction  handshake                      carries
//   in_      in         in_valid / in_ready            one item: func and operands
//   out_     out        out_valid / out_ready          one result item per input item
//   cfg_     in/out     psel, penable, pwrite, pready  lookup_disabled at byte address 0
//
// insert, clear and disabled lookup: no table read; the result goes from the response state to the output register
// lookup and prefix query: a table scan, one table ram read a cycle until the first match or
//   the last stored entry (the single read port of the entry rams sets this)
// reset clears the entry count and the control state; ram contents are never cleared,
//   only entries below the count are read, so no clearing pass is needed
// a result waiting in the output register does not stop the next item being accepted
module ip_prefix_range_owner_lookup import iprol_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [FUNC_W-1:0]     in_func,
  input  logic [ADDR_W-1:0]     in_client_address,
  input  logic [PREFIX_W-1:0]   in_net_prefix,
  input  logic [OCTET_W-1:0]    in_range_first,
  input  logic [OCTET_W-1:0]    in_range_last,
  input  logic [OWNER_W-1:0]    in_owner_in,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic                  out_hit,
  output logic [OWNER_W-1:0]    out_owner_out,
  output logic                  out_prefix_present,
  output logic                  out_insert_rejected,
  input  logic                  cfg_psel,
  input  logic                  cfg_penable,
  input  logic                  cfg_pwrite,
  input  logic [CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [CFG_DATA_W-1:0] cfg_pwdata,
  output logic [CFG_DATA_W-1:0] cfg_prdata,
  output logic                  cfg_pready
);

  logic               lookup_disabled_r, lookup_disabled_nxt;
  logic               out_valid_r, out_valid_nxt;
  res_t               out_res_r;
  mem_req_t           mem_req;
  key_t               rd_key;
  logic [KEY_W-1:0]   rd_key_bits;
  logic [OWNER_W-1:0] rd_owner;
  logic               res_valid;
  logic               res_take;
  res_t               res;
  logic               cfg_wr;

  // configuration register
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready &&
                      (cfg_paddr == REG_LOOKUP_DISABLED);
  assign lookup_disabled_nxt = cfg_wr ? cfg_pwdata[0] : lookup_disabled_r;
  assign cfg_prdata = (cfg_paddr == REG_LOOKUP_DISABLED) ?
                      {{(CFG_DATA_W-1){1'b0}}, lookup_disabled_r} : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lookup_disabled_r <= 1'b0;
    end else begin
      lookup_disabled_r <= lookup_disabled_nxt;
    end
  end

  // sequencer
  iprol_ctrl u_ctrl (
    .clk               (clk),
    .rst_n             (rst_n),
    .lookup_disabled   (lookup_disabled_r),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_func           (in_func),
    .in_client_address (in_client_address),
    .in_net_prefix     (in_net_prefix),
    .in_range_first    (in_range_first),
    .in_range_last     (in_range_last),
    .in_owner_in       (in_owner_in),
    .mem_req           (mem_req),
    .rd_key            (rd_key),
    .rd_owner          (rd_owner),
    .res_valid         (res_valid),
    .res_take          (res_take),
    .res               (res)
  );

  // entry key and owner memories
  iprol_ram #(.WIDTH(KEY_W), .DEPTH(TABLE_DEPTH)) u_key_ram (
    .clk   (clk),
    .we    (mem_req.we),
    .waddr (mem_req.waddr),
    .wdata (mem_req.wkey),
    .re    (mem_req.re),
    .raddr (mem_req.raddr),
    .rdata (rd_key_bits)
  );

  assign rd_key = key_t'(rd_key_bits);

  iprol_ram #(.WIDTH(OWNER_W), .DEPTH(TABLE_DEPTH)) u_owner_ram (
    .clk   (clk),
    .we    (mem_req.we),
    .waddr (mem_req.waddr),
    .wdata (mem_req.wowner),
    .re    (mem_req.re),
    .raddr (mem_req.raddr),
    .rdata (rd_owner)
  );

  // output register
  assign res_take      = res_valid && (!out_valid_r || out_ready);
  assign out_valid_nxt = res_take ? 1'b1 : (out_ready ? 1'b0 : out_valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res_take) begin
      out_res_r <= res;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_hit             = out_res_r.hit;
  assign out_owner_out       = out_res_r.owner;
  assign out_prefix_present  = out_res_r.present;
  assign out_insert_rejected = out_res_r.rejected;

endmodule

FILE: design/iprol_ram.sv
// generic single write port, single read port ram with registered read data
module iprol_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read port, registered read data
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: design/iprol_ctrl.sv
// sequencer: decodes items, appends and clears entries and scans the table one entry a cycle
module iprol_ctrl import iprol_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                lookup_disabled,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [FUNC_W-1:0]   in_func,
  input  logic [ADDR_W-1:0]   in_client_address,
  input  logic [PREFIX_W-1:0] in_net_prefix,
  input  logic [OCTET_W-1:0]  in_range_first,
  input  logic [OCTET_W-1:0]  in_range_last,
  input  logic [OWNER_W-1:0]  in_owner_in,
  output mem_req_t            mem_req,
  input  key_t                rd_key,
  input  logic [OWNER_W-1:0]  rd_owner,
  output logic                res_valid,
  input  logic                res_take,
  output res_t                res
);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_SCAN = 3'b010,
    ST_RESP = 3'b100
  } state_t;

  state_t              state_r, state_nxt;
  logic [CNT_W-1:0]    count_r, count_nxt;
  logic [CNT_W-1:0]    idx_r, idx_nxt;
  logic                rd_vld_r, rd_vld_nxt;
  logic                is_lookup_r, is_lookup_nxt;
  logic [PREFIX_W-1:0] q_prefix_r, q_prefix_nxt;
  logic [OCTET_W-1:0]  q_octet_r, q_octet_nxt;
  res_t                res_r, res_nxt;

  func_t func;
  logic  full;
  logic  match;
  logic  scan_issue;

  assign func = func_t'(in_func);
  assign full = (count_r == CNT_W'(TABLE_DEPTH));

  // compare the entry read last cycle against the held query
  assign match = (rd_key.prefix == q_prefix_r) &&
                 (!is_lookup_r || ((rd_key.first <= q_octet_r) && (q_octet_r <= rd_key.last)));

  // keep reading while entries remain and no match has come back
  assign scan_issue = (state_r == ST_SCAN) && !(rd_vld_r && match) && (idx_r < count_r);

  // table access; writes only happen on accept in idle, so reads never overlap them
  always_comb begin
    mem_req.we     = in_valid && (state_r == ST_IDLE) && (func == FUNC_INSERT) && !full;
    mem_req.waddr  = count_r[IDX_W-1:0];
    mem_req.wkey   = '{prefix: in_net_prefix, first: in_range_first, last: in_range_last};
    mem_req.wowner = in_owner_in;
    mem_req.re     = scan_issue;
    mem_req.raddr  = idx_r[IDX_W-1:0];
  end

  assign in_ready  = (state_r == ST_IDLE);
  assign res_valid = (state_r == ST_RESP);
  assign res       = res_r;

  // next state
  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    idx_nxt       = idx_r;
    rd_vld_nxt    = rd_vld_r;
    is_lookup_nxt = is_lookup_r;
    q_prefix_nxt  = q_prefix_r;
    q_octet_nxt   = q_octet_r;
    res_nxt       = res_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          res_nxt       = '0;
          idx_nxt       = '0;
          rd_vld_nxt    = 1'b0;
          is_lookup_nxt = (func == FUNC_LOOKUP);
          q_prefix_nxt  = (func == FUNC_LOOKUP) ? in_client_address[PREFIX_W-1:0]
                                                : in_net_prefix;
          q_octet_nxt   = in_client_address[ADDR_W-1 -: OCTET_W];
          case (func)
            FUNC_LOOKUP: begin
              state_nxt = lookup_disabled ? ST_RESP : ST_SCAN;
            end
            FUNC_INSERT: begin
              if (full) begin
                res_nxt.rejected = 1'b1;
              end else begin
                count_nxt = count_r + CNT_W'(1);
              end
              state_nxt = ST_RESP;
            end
            FUNC_CLEAR: begin
              count_nxt = '0;
              state_nxt = ST_RESP;
            end
            FUNC_QUERY: begin
              state_nxt = ST_SCAN;
            end
            default: begin
              state_nxt = ST_RESP;
            end
          endcase
        end
      end
      ST_SCAN: begin
        rd_vld_nxt = scan_issue;
        if (scan_issue) begin
          idx_nxt = idx_r + CNT_W'(1);
        end
        if (rd_vld_r && match) begin
          if (is_lookup_r) begin
            res_nxt.hit   = 1'b1;
            res_nxt.owner = rd_owner;
          end else begin
            res_nxt.present = 1'b1;
          end
          state_nxt = ST_RESP;
        end else if (!scan_issue && !rd_vld_r) begin
          // every stored entry checked without a match
          state_nxt = ST_RESP;
        end
      end
      ST_RESP: begin
        if (res_take) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      count_r  <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      count_r  <= count_nxt;
      rd_vld_r <= rd_vld_nxt;
    end
  end

  // query and result registers
  always_ff @(posedge clk) begin
    idx_r       <= idx_nxt;
    is_lookup_r <= is_lookup_nxt;
    q_prefix_r  <= q_prefix_nxt;
    q_octet_r   <= q_octet_nxt;
    res_r       <= res_nxt;
  end

endmodule

FILE: design/iprol_chk.sv
// port level checks for the address range owner lookup table, with its bind
module iprol_chk import iprol_pkg::*; (
  input logic               clk,
  input logic               rst_n,
  input logic               out_valid,
  input logic               out_ready,
  input logic               out_hit,
  input logic [OWNER_W-1:0] out_owner_out,
  input logic               out_prefix_present,
  input logic               out_insert_rejected,
  input logic               cfg_pready
);

  // a result item holds until taken
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result item dropped before it was taken");

  // reset empties the output register
  a_out_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result item shown straight after reset");

  // a result item reports at most one kind of outcome
  a_one_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $countones({out_hit, out_prefix_present, out_insert_rejected}) <= 1)
    else $error("result item mixes outcomes of different operations");

  // a miss carries a zero owner
  a_miss_owner: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_hit |-> out_owner_out == '0)
    else $error("owner reported without a hit");

  // configuration port never stalls
  a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_pready)
    else $error("configuration port stalled");

endmodule

bind ip_prefix_range_owner_lookup iprol_chk u_iprol_chk (
  .clk                 (clk),
  .rst_n               (rst_n),
  .out_valid           (out_valid),
  .out_ready           (out_ready),
  .out_hit             (out_hit),
  .out_owner_out       (out_owner_out),
  .out_prefix_present  (out_prefix_present),
  .out_insert_rejected (out_insert_rejected),
  .cfg_pready          (cfg_pready)
);
